>>> design/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants for the byte-stream interpreter
// Request structs, command characters, status codes and store sizes.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int TAPE_LEN   = 32768;
    localparam int LOOP_LEN   = 1024;
    localparam int NEST_DEPTH = 64;

    localparam int HW = $clog2(TAPE_LEN);
    localparam int LW = $clog2(LOOP_LEN);
    localparam int SW = $clog2(NEST_DEPTH);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DATA  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_in_req;

    typedef struct packed {
        logic       wrote;
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_out_req;

endpackage

>>> design/brainfuck_machine.sv
// ----------------------------------------------------------------------------
// brainfuck_machine: byte-stream interpreter over a byte tape
// Executes commands directly, captures loops into a buffer and runs them.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_stall  | t_in_req  (action, in_byte)
//   out     | output    | o_valid / i_stall  | t_out_req (wrote, out_byte, status)
//
// Each request passes a fetch step, which issues the reads (tape cell,
// loop text, jump entry, open stack), and then an execute step, which writes
// back and loads the result register.
// After reset a clearing pass sweeps the tape, one cell a cycle, and no
// request is accepted until it has finished.
// The result register holds while stalled; a new request is accepted once
// the previous one has finished executing and the register is empty or
// being drained, so requests never overlap in the block.
module brainfuck_machine
    import bfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_in,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_out
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_CAPT = 2'd1;
    localparam logic [1:0] M_RUN  = 2'd2;
    localparam logic [1:0] M_ERR  = 2'd3;

    // stores
    logic [7:0]    tape [TAPE_LEN];
    logic [7:0]    code [LOOP_LEN];
    logic [LW-1:0] jump [LOOP_LEN];
    logic [LW-1:0] stk  [NEST_DEPTH];

    logic [7:0]    r_cell, r_code;
    logic [LW-1:0] r_jump, r_stk;

    // control
    logic          r_clr;
    logic [HW:0]   r_clr_cnt;
    logic          r_busy;
    t_in_req       r_req;
    logic [HW-1:0] r_head;
    logic [SW:0]   r_top;
    logic [LW:0]   r_len;
    logic [LW-1:0] r_pc;
    logic [1:0]    r_mode;
    logic          r_rdp;
    logic          r_ov;
    t_out_req      r_out;

    logic accept;
    assign o_stall = r_clr || r_busy || (r_ov && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_out   = r_out;

    // fetch: read every store the request may need
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell <= tape[r_head];
            r_code <= code[r_pc];
            r_jump <= jump[r_pc];
            r_stk  <= stk[r_top[SW-1:0] - 1'b1];
        end
    end

    // execute
    logic          n_wrote;
    logic [7:0]    n_cell;
    logic          we_cell, we_code, we_stk, we_j1, we_j2;
    logic [LW-1:0] j_addr1, j_addr2, j_dat1, j_dat2;
    logic [HW-1:0] n_head;
    logic [SW:0]   n_top;
    logic [LW:0]   n_len;
    logic [LW-1:0] n_pc;
    logic [1:0]    n_mode;
    logic          n_rdp;
    logic [7:0]    op;
    logic          do_op;
    logic          cap;
    logic [SW:0]   cap_top;
    logic [LW:0]   cap_len;
    logic [LW:0]   pc_ext, jp1;

    always_comb begin
        n_wrote = 1'b0;
        n_cell  = r_cell;
        we_cell = 1'b0;
        we_code = 1'b0;
        we_stk  = 1'b0;
        we_j1   = 1'b0;
        we_j2   = 1'b0;
        j_addr1 = r_stk;
        j_dat1  = r_len[LW-1:0];
        j_addr2 = r_len[LW-1:0];
        j_dat2  = r_stk;
        n_head  = r_head;
        n_top   = r_top;
        n_len   = r_len;
        n_pc    = r_pc;
        n_mode  = r_mode;
        n_rdp   = r_rdp;
        op      = r_req.in_byte;
        do_op   = 1'b0;
        cap     = 1'b0;
        cap_top = r_top;
        cap_len = r_len;
        pc_ext  = {1'b0, r_pc};
        jp1     = {1'b0, r_jump} + 1'b1;

        if (r_mode != M_ERR) begin
            if (r_rdp) begin
                if (!r_req.action) begin
                    n_cell  = r_req.in_byte;
                    we_cell = 1'b1;
                    n_rdp   = 1'b0;
                end
            end else if (r_req.action) begin
                if (r_mode == M_RUN) begin
                    if (pc_ext >= r_len) begin
                        n_mode = M_IDLE;
                    end else if (r_code == CH_OPEN) begin
                        if (r_cell == 8'd0) begin
                            if (jp1 >= r_len) begin
                                n_mode = M_IDLE;
                                n_pc   = '0;
                            end else begin
                                n_pc = jp1[LW-1:0];
                            end
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end else if (r_code == CH_CLOSE) begin
                        n_pc = r_jump;
                    end else begin
                        op    = r_code;
                        do_op = 1'b1;
                        n_pc  = r_pc + 1'b1;
                    end
                end
            end else if (r_mode == M_CAPT) begin
                cap = 1'b1;
            end else if (r_mode == M_IDLE) begin
                if (r_req.in_byte == CH_OPEN) begin
                    cap     = 1'b1;
                    cap_top = '0;
                    cap_len = '0;
                    n_mode  = M_CAPT;
                end else if (r_req.in_byte == CH_CLOSE) begin
                    n_mode = M_ERR;
                end else begin
                    do_op = 1'b1;
                end
            end
        end

        if (cap) begin
            n_top   = cap_top;
            n_len   = cap_len;
            j_addr2 = cap_len[LW-1:0];
            j_dat1  = cap_len[LW-1:0];
            if (cap_len >= (LW+1)'(LOOP_LEN)) begin
                n_mode = M_ERR;
            end else if (r_req.in_byte == CH_OPEN
                         && cap_top >= (SW+1)'(NEST_DEPTH)) begin
                n_mode = M_ERR;
            end else begin
                we_code = 1'b1;
                n_len   = cap_len + 1'b1;
                if (r_req.in_byte == CH_OPEN) begin
                    we_stk = 1'b1;
                    n_top  = cap_top + 1'b1;
                end else if (r_req.in_byte == CH_CLOSE && cap_top != '0) begin
                    we_j1 = 1'b1;
                    we_j2 = 1'b1;
                    n_top = cap_top - 1'b1;
                    if (cap_top == (SW+1)'(1)) begin
                        n_mode = M_RUN;
                        n_pc   = '0;
                    end
                end
            end
        end

        if (do_op) begin
            unique case (op)
                CH_LT:    n_head = r_head - 1'b1;
                CH_GT:    n_head = r_head + 1'b1;
                CH_PLUS:  begin n_cell = r_cell + 8'd1; we_cell = 1'b1; end
                CH_MINUS: begin n_cell = r_cell - 8'd1; we_cell = 1'b1; end
                CH_COMMA: n_rdp = 1'b1;
                CH_DOT:   n_wrote = 1'b1;
                default:  ;
            endcase
        end
    end

    // write back
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            tape[r_clr_cnt[HW-1:0]] <= 8'd0;
        end else if (r_busy && we_cell) begin
            tape[r_head] <= n_cell;
        end
        if (r_busy && we_code) code[cap_len[LW-1:0]] <= r_req.in_byte;
        if (r_busy && we_stk)  stk[cap_top[SW-1:0]] <= cap_len[LW-1:0];
        if (r_busy && we_j1)   jump[j_addr1] <= j_dat1;
        if (r_busy && we_j2)   jump[j_addr2] <= j_dat2;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_in;
        if (r_busy) begin
            r_out.wrote    <= n_wrote;
            r_out.out_byte <= n_wrote ? r_cell : 8'd0;
            r_out.status   <= (n_mode == M_ERR) ? ST_ERROR :
                              n_rdp ? ST_DATA :
                              (n_mode == M_RUN) ? ST_RUN : ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_busy    <= 1'b0;
            r_ov      <= 1'b0;
            r_head    <= '0;
            r_top     <= '0;
            r_len     <= '0;
            r_pc      <= '0;
            r_mode    <= M_IDLE;
            r_rdp     <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (HW+1)'(TAPE_LEN - 1)) r_clr <= 1'b0;
            end
            r_busy <= accept;
            if (r_busy) begin
                r_ov   <= 1'b1;
                r_head <= n_head;
                r_top  <= n_top;
                r_len  <= n_len;
                r_pc   <= n_pc;
                r_mode <= n_mode;
                r_rdp  <= n_rdp;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

>>> tb/tb_brainfuck_machine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_brainfuck_machine: self-checking bench for the byte-stream interpreter
// Drives code bytes, data bytes and execution ticks with random gaps and
// output back-pressure, predicts every result with a local interpreter and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_brainfuck_machine;
    import bfm_pkg::*;

    // Internal interpreter phases; status shows run and halt (as error), while capture reports as idle.
    typedef enum logic [1:0] {M_IDLE, M_CAPTURE, M_RUN, M_HALT} t_phase;

    localparam int WATCHDOG_LIMIT = 200000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_in_req  i_in = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_out_req o_out;

    brainfuck_machine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Interpreter copy: tape, head, captured loop text and bracket links
    // ------------------------------------------------------------------
    logic [7:0]    tape [TAPE_LEN];
    int            head;
    logic [7:0]    loop_text [LOOP_LEN];
    int            bracket_link [LOOP_LEN];
    int            open_pos [NEST_DEPTH];
    int            depth;
    int            text_len;
    int            pc;
    t_phase        phase;
    bit            data_wait;

    t_out_req      expected_q [$];
    int            errors = 0;
    int            reqs_sent = 0;
    bit            calm = 1'b0;       // no gaps, no stalls while set
    bit            hold_out = 1'b0;   // request for a long output hold-off
    bit            in_fire, out_fire;

    // Plain command; returns 1 when the cell is written out.
    function automatic bit plain_cmd(logic [7:0] c);
        case (c)
            CH_LT:    head = (head + TAPE_LEN - 1) % TAPE_LEN;
            CH_GT:    head = (head + 1) % TAPE_LEN;
            CH_PLUS:  tape[head] = tape[head] + 8'd1;
            CH_MINUS: tape[head] = tape[head] - 8'd1;
            CH_COMMA: data_wait = 1'b1;
            CH_DOT:   return 1'b1;
            default:  ;
        endcase
        return 1'b0;
    endfunction

    function automatic void capture(logic [7:0] c);
        int pos;
        int op;
        pos = text_len;
        if (pos >= LOOP_LEN) begin
            phase = M_HALT;
            return;
        end
        if (c == CH_OPEN) begin
            if (depth >= NEST_DEPTH) begin
                phase = M_HALT;
                return;
            end
            open_pos[depth] = pos;
            depth++;
        end
        loop_text[pos] = c;
        text_len = pos + 1;
        if (c == CH_CLOSE && depth > 0) begin
            op = open_pos[depth - 1] % LOOP_LEN;
            depth--;
            bracket_link[op] = pos;
            bracket_link[pos] = op;
            if (depth == 0) begin
                phase = M_RUN;
                pc = 0;
            end
        end
    endfunction

    function automatic bit loop_tick();
        int p;
        logic [7:0] c;
        bit wr;
        p = pc;
        wr = 1'b0;
        if (p >= text_len || p >= LOOP_LEN) begin
            phase = M_IDLE;
            return 1'b0;
        end
        c = loop_text[p];
        if (c == CH_OPEN) begin
            if (tape[head] == 8'd0) begin
                p = bracket_link[p] % LOOP_LEN;
                if (p + 1 >= text_len) begin
                    phase = M_IDLE;
                    pc = 0;
                    return 1'b0;
                end
            end
            p++;
        end else if (c == CH_CLOSE) begin
            p = bracket_link[p] % LOOP_LEN;
        end else begin
            wr = plain_cmd(c);
            p++;
        end
        pc = p;
        return wr;
    endfunction

    // Advance the interpreter by one request and queue the result it gives.
    function automatic void interpret(t_in_req r);
        t_out_req res;
        bit wr;
        wr = 1'b0;
        if (phase != M_HALT) begin
            if (data_wait) begin
                if (!r.action) begin
                    tape[head] = r.in_byte;
                    data_wait = 1'b0;
                end
            end else if (r.action) begin
                if (phase == M_RUN) wr = loop_tick();
            end else if (phase == M_CAPTURE) begin
                capture(r.in_byte);
            end else if (phase == M_IDLE) begin
                if (r.in_byte == CH_OPEN) begin
                    text_len = 0;
                    depth = 0;
                    phase = M_CAPTURE;
                    capture(r.in_byte);
                end else if (r.in_byte == CH_CLOSE) begin
                    phase = M_HALT;
                end else begin
                    wr = plain_cmd(r.in_byte);
                end
            end
        end
        res.wrote    = wr;
        res.out_byte = wr ? tape[head] : 8'd0;
        if (phase == M_HALT)     res.status = ST_ERROR;
        else if (data_wait)      res.status = ST_DATA;
        else if (phase == M_RUN) res.status = ST_RUN;
        else                     res.status = ST_IDLE;
        expected_q.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Random stream byte; brackets are turned into a neighbouring ignored
    // character so that random code never halts the block or opens a loop
    // that cannot end.
    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CH_OPEN || b == CH_CLOSE) b = b ^ 8'h01;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Request sender: hold the request until accepted, then maybe idle
    // ------------------------------------------------------------------
    task automatic send_req(input logic act, input logic [7:0] b);
        t_in_req r;
        int gap;
        r.action  = act;
        r.in_byte = b;
        i_valid <= 1'b1;
        i_in    <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        interpret(r);
        reqs_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[k]) send_req(1'b0, s[k]);
    endtask

    // Feed ticks and data until the captured loop has finished.
    task automatic drain_loop();
        int guard;
        guard = 0;
        while ((phase == M_RUN || data_wait) && phase != M_HALT && guard < 20000) begin
            if (data_wait) begin
                // occasionally offer a tick that the pending read ignores
                if ($urandom_range(9) == 0) send_req(1'b1, 8'($urandom));
                else send_req(1'b0, 8'($urandom_range(6)));
            end else if ($urandom_range(19) == 0) begin
                send_req(1'b0, 8'($urandom));   // stray stream byte, ignored
            end else begin
                send_req(1'b1, 8'($urandom));
            end
            guard++;
        end
    endtask

    // Random terminating loop: the loop cell drops by one per pass while
    // the body works on the neighbouring cell and returns.
    task automatic send_random_loop();
        int n;
        string ops;
        ops = "+-.,x>";
        send_text("[->");
        n = $urandom_range(6);
        repeat (n) begin
            case ($urandom_range(5))
                0: send_text("[-]");
                1: send_req(1'b0, rand_byte());
                default: send_req(1'b0, ops[$urandom_range(3)]);
            endcase
        end
        send_text("<]");
        drain_loop();
    endtask

    // ------------------------------------------------------------------
    // Result checker and output stall generator
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, wrote", o_out.wrote, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_out.wrote !== want.wrote)
                    report_mismatch("wrote", o_out.wrote, want.wrote);
                if (o_out.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_out.out_byte, want.out_byte);
                if (o_out.status !== want.status)
                    report_mismatch("status", o_out.status, want.status);
            end
        end
    end

    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                // long hold-off so the block fills up and stalls its input
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_out = 1'b0;
                i_stall <= 1'b0;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            in_fire  = i_valid && !o_stall;
            out_fire = o_valid && !i_stall;
            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("brainfuck_machine: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_plain_commands();
        // wrap the cell down and up, wrap the head below zero and back
        send_text("-.+.<+.>.x");
        send_req(1'b1, 8'hFF);          // tick at top level, ignored
    endtask

    task automatic test_data_read();
        send_text(",");
        send_req(1'b1, 8'h00);          // tick while a read waits, ignored
        send_req(1'b0, 8'hA5);
        send_text(".,");
        send_req(1'b0, 8'h5A);
        send_text(".");
    endtask

    task automatic test_directed_loop();
        send_text("+++[->+<]>.<");
        drain_loop();
        send_text("[.]");               // zero cell: loop skipped at once
        drain_loop();
    endtask

    task automatic test_random_stream();
        int r;
        while (reqs_sent < 1000) begin
            calm = (reqs_sent % 300) > 240;
            r = $urandom_range(99);
            if (r < 15) begin
                repeat ($urandom_range(4)) send_req(1'b0, CH_PLUS);
                send_random_loop();
            end else if (r < 20) begin
                send_req(1'b1, 8'($urandom));
            end else begin
                send_req(1'b0, rand_byte());
                if (phase == M_CAPTURE || phase == M_RUN || data_wait) begin
                    // a random ',' left a read pending: feed data until it is served
                    if (phase == M_CAPTURE) send_text("]");
                    drain_loop();
                end
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_out = 1'b1;
        repeat (20) send_req(1'b0, CH_DOT);
    endtask

    task automatic test_error_halt();
        // move the head left and back, leaving it where it was
        send_text("<>");
        send_text("]");
        send_text("+.[");
        send_req(1'b1, 8'h00);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (tape[k]) tape[k] = 8'd0;
        head = 0;
        depth = 0;
        text_len = 0;
        pc = 0;
        phase = M_IDLE;
        data_wait = 1'b0;

        test_plain_commands();
        test_data_read();
        test_directed_loop();
        test_random_stream();
        test_backpressure();
        test_error_halt();

        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("brainfuck_machine: match");
        end else begin
            $display("brainfuck_machine: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bfm_pkg.sv
design/brainfuck_machine.sv
tb/tb_brainfuck_machine.sv
